// ===== hdl/ordered_rule_classifier_defines.svh =====
// Assertion macros for the ordered rule classifier.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef ORDERED_RULE_CLASSIFIER_DEFINES_SVH
`define ORDERED_RULE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, muted during reset.
`define ORC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted during reset.
`define ORC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/orc_pkg.sv =====
// Shared types and constants of the ordered rule classifier.
// No dependencies; imported by orc_if, orc_ctrl, orc_datapath, the top level and the testbench.
`default_nettype none

package orc_pkg;

    localparam int OP_W    = 2;
    localparam int SLOT_W  = 2;
    localparam int ADRS_W  = 32;
    localparam int CLASS_W = 3;
    localparam int IDENT_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CLASSIFY = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef enum logic [2:0] {
        RES_FAIL,
        RES_ADD_OK,
        RES_REMOVE_OK,
        RES_CLASS_HIT,
        RES_CLASS_MISS
    } res_kind_t;

    typedef struct packed {
        logic [ADRS_W-1:0]  src;
        logic [ADRS_W-1:0]  dst;
        logic [CLASS_W-1:0] cls;
        logic [IDENT_W-1:0] ident;
    } rule_entry_t;

    typedef struct packed {
        logic            item_load;
        logic            scan_start;
        logic            scan_adv;
        logic            wr_add;
        logic            wr_shift;
        logic            fill_inc;
        logic            fill_dec;
        logic            res_set;
        res_kind_t       res_kind;
        logic            out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            slot_ok;
        logic            full;
        logic            rid_zero;
        logic            fill_zero;
        logic            last;
        logic            match_cls;
        logic            match_id;
        logic            out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/orc_if.sv =====
// Request and response channel interfaces of the ordered rule classifier.
// Depends on orc_pkg for field widths.
`default_nettype none

interface orc_req_if;
    import orc_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [SLOT_W-1:0]  policy_slot;
    logic [ADRS_W-1:0]  source_address;
    logic [ADRS_W-1:0]  destination_address;
    logic [CLASS_W-1:0] class_in;
    logic [IDENT_W-1:0] rule_ident_in;

    modport source (
        output valid, operation, policy_slot, source_address, destination_address,
               class_in, rule_ident_in,
        input  ready
    );
    modport sink (
        input  valid, operation, policy_slot, source_address, destination_address,
               class_in, rule_ident_in,
        output ready
    );
endinterface

interface orc_resp_if;
    import orc_pkg::*;

    logic               valid;
    logic               ready;
    logic               status;
    logic [IDENT_W-1:0] rule_ident_out;
    logic [CLASS_W-1:0] class_out;

    modport source (
        output valid, status, rule_ident_out, class_out,
        input  ready
    );
    modport sink (
        input  valid, status, rule_ident_out, class_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/orc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module orc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/orc_ctrl.sv =====
// Sequencer of the ordered rule classifier: decode, table walk, shift, deliver.
// Depends on orc_pkg; drives the datapath through ctrl_cmd_t only.
`default_nettype none

module orc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire orc_pkg::dp_status_t st,
    output orc_pkg::ctrl_cmd_t       cmd
);
    import orc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESP;
                if (st.slot_ok && !st.fill_zero)
                begin
                    if ((st.op == OP_REMOVE && !st.rid_zero) || st.op == OP_CLASSIFY)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (st.op == OP_CLASSIFY)
                begin
                    if (st.match_cls || st.last)
                    begin
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    if (st.last)
                    begin
                        state_next = S_RESP;
                    end
                    else if (st.match_id)
                    begin
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                if (st.last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        cmd.res_kind = RES_FAIL;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.item_load = in_valid;
            end
            S_DECODE:
            begin
                cmd.res_set = 1'b1;
                if (st.slot_ok)
                begin
                    case (st.op)
                        OP_ADD:
                        begin
                            if (!st.full)
                            begin
                                cmd.wr_add   = 1'b1;
                                cmd.fill_inc = 1'b1;
                                cmd.res_kind = RES_ADD_OK;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!st.rid_zero && !st.fill_zero)
                            begin
                                cmd.res_set    = 1'b0;
                                cmd.scan_start = 1'b1;
                            end
                        end
                        OP_CLASSIFY:
                        begin
                            if (st.fill_zero)
                            begin
                                cmd.res_kind = RES_CLASS_MISS;
                            end
                            else
                            begin
                                cmd.res_set    = 1'b0;
                                cmd.scan_start = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.res_kind = RES_FAIL;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (st.op == OP_CLASSIFY)
                begin
                    if (st.match_cls)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_kind = RES_CLASS_HIT;
                    end
                    else if (st.last)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_kind = RES_CLASS_MISS;
                    end
                    else
                    begin
                        cmd.scan_adv = 1'b1;
                    end
                end
                else
                begin
                    if (st.match_id && st.last)
                    begin
                        cmd.fill_dec = 1'b1;
                        cmd.res_set  = 1'b1;
                        cmd.res_kind = RES_REMOVE_OK;
                    end
                    else if (st.last)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_kind = RES_FAIL;
                    end
                    else
                    begin
                        cmd.scan_adv = 1'b1;
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.wr_shift = 1'b1;
                if (st.last)
                begin
                    cmd.fill_dec = 1'b1;
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = RES_REMOVE_OK;
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                end
            end
            S_RESP:
            begin
                cmd.out_load = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/orc_datapath.sv =====
// Datapath of the ordered rule classifier: item latch, fill counts, identifier
// counter, rule RAM, match logic and output register. Depends on orc_pkg, orc_ram.
`default_nettype none

module orc_datapath #(
    parameter int POLICY_SLOTS     = 4,
    parameter int RULES_PER_POLICY = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire orc_pkg::ctrl_cmd_t             cmd,
    output orc_pkg::dp_status_t                 st,
    input  wire logic [orc_pkg::OP_W-1:0]       operation,
    input  wire logic [orc_pkg::SLOT_W-1:0]     policy_slot,
    input  wire logic [orc_pkg::ADRS_W-1:0]     source_address,
    input  wire logic [orc_pkg::ADRS_W-1:0]     destination_address,
    input  wire logic [orc_pkg::CLASS_W-1:0]    class_in,
    input  wire logic [orc_pkg::IDENT_W-1:0]    rule_ident_in,
    input  wire logic                           cfg_we,
    input  wire logic [orc_pkg::CLASS_W-1:0]    cfg_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                status,
    output logic [orc_pkg::IDENT_W-1:0]         rule_ident_out,
    output logic [orc_pkg::CLASS_W-1:0]         class_out
);
    import orc_pkg::*;

    localparam int DEPTH   = POLICY_SLOTS * RULES_PER_POLICY;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SIDX_W  = (POLICY_SLOTS > 1) ? $clog2(POLICY_SLOTS) : 1;
    localparam int IDX_W   = (RULES_PER_POLICY > 1) ? $clog2(RULES_PER_POLICY) : 1;
    localparam int FILL_W  = $clog2(RULES_PER_POLICY + 1);
    localparam int ENTRY_W = $bits(rule_entry_t);

    // latched item
    logic [OP_W-1:0]    op_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [ADRS_W-1:0]  src_reg;
    logic [ADRS_W-1:0]  dst_reg;
    logic [CLASS_W-1:0] cls_reg;
    logic [IDENT_W-1:0] rid_reg;

    logic [FILL_W-1:0]  fill_reg [POLICY_SLOTS];
    logic [IDENT_W-1:0] ident_reg;
    logic [IDENT_W-1:0] ident_next;
    logic [CLASS_W-1:0] best_class_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;

    logic               res_status_reg;
    logic [IDENT_W-1:0] res_ident_reg;
    logic [CLASS_W-1:0] res_class_reg;
    logic               out_valid_reg;
    logic               out_status_reg;
    logic [IDENT_W-1:0] out_ident_reg;
    logic [CLASS_W-1:0] out_class_reg;

    logic [SIDX_W-1:0]  slot_idx;
    logic               slot_ok;
    logic [FILL_W-1:0]  cur_fill;
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  raddr;
    logic [ADDR_W-1:0]  waddr;
    logic               we;
    rule_entry_t        wentry;
    rule_entry_t        rentry;
    logic [ENTRY_W-1:0] rdata;

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            op_reg   <= operation;
            slot_reg <= policy_slot;
            src_reg  <= source_address;
            dst_reg  <= destination_address;
            cls_reg  <= class_in;
            rid_reg  <= rule_ident_in;
        end
    end

    assign slot_idx = SIDX_W'(slot_reg);
    assign slot_ok  = (32'(slot_reg) < POLICY_SLOTS);
    assign cur_fill = slot_ok ? fill_reg[slot_idx] : '0;
    assign base     = ADDR_W'(32'(slot_idx) * RULES_PER_POLICY);

    // walk index; the RAM reads at the next index so its data lines up with idx_reg
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.scan_start)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_adv)
        begin
            idx_next = IDX_W'(FILL_W'(idx_reg) + FILL_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    // fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POLICY_SLOTS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < POLICY_SLOTS; i++)
            begin
                if (slot_ok && slot_idx == SIDX_W'(i))
                begin
                    if (cmd.fill_inc)
                    begin
                        fill_reg[i] <= fill_reg[i] + FILL_W'(1);
                    end
                    else if (cmd.fill_dec)
                    begin
                        fill_reg[i] <= fill_reg[i] - FILL_W'(1);
                    end
                end
            end
        end
    end

    // identifier counter: skip zero on wrap
    assign ident_next = (ident_reg == '1) ? IDENT_W'(1) : ident_reg + IDENT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg      <= IDENT_W'(1);
            best_class_reg <= '0;
        end
        else
        begin
            if (cmd.wr_add)
            begin
                ident_reg <= ident_next;
            end
            if (cfg_we)
            begin
                best_class_reg <= cfg_data;
            end
        end
    end

    // rule RAM
    assign rentry = rule_entry_t'(rdata);
    assign raddr  = base + ADDR_W'(idx_next);
    assign we     = cmd.wr_add || cmd.wr_shift;

    always_comb
    begin
        if (cmd.wr_add)
        begin
            waddr        = base + ADDR_W'(cur_fill);
            wentry.src   = src_reg;
            wentry.dst   = dst_reg;
            wentry.cls   = cls_reg;
            wentry.ident = ident_reg;
        end
        else
        begin
            // shift the entry just read one place down
            waddr  = base + ADDR_W'(idx_reg) - ADDR_W'(1);
            wentry = rentry;
        end
    end

    orc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_rule_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (ENTRY_W'(wentry)),
        .raddr (raddr),
        .rdata (rdata)
    );

    // status to the sequencer
    always_comb
    begin
        st.op        = op_reg;
        st.slot_ok   = slot_ok;
        st.full      = (cur_fill >= FILL_W'(RULES_PER_POLICY));
        st.rid_zero  = (rid_reg == '0);
        st.fill_zero = (cur_fill == '0);
        st.last      = ((FILL_W'(idx_reg) + FILL_W'(1)) >= cur_fill);
        st.match_cls = (rentry.src == src_reg) && (rentry.dst == dst_reg);
        st.match_id  = (rentry.ident == rid_reg);
        st.out_free  = !out_valid_reg || out_ready;
    end

    // pending result
    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            case (cmd.res_kind)
                RES_ADD_OK:
                begin
                    res_status_reg <= 1'b0;
                    res_ident_reg  <= ident_reg;
                    res_class_reg  <= '0;
                end
                RES_REMOVE_OK:
                begin
                    res_status_reg <= 1'b0;
                    res_ident_reg  <= '0;
                    res_class_reg  <= '0;
                end
                RES_CLASS_HIT:
                begin
                    res_status_reg <= 1'b0;
                    res_ident_reg  <= '0;
                    res_class_reg  <= rentry.cls;
                end
                RES_CLASS_MISS:
                begin
                    res_status_reg <= 1'b0;
                    res_ident_reg  <= '0;
                    res_class_reg  <= best_class_reg;
                end
                default:
                begin
                    res_status_reg <= 1'b1;
                    res_ident_reg  <= '0;
                    res_class_reg  <= '0;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_ident_reg  <= res_ident_reg;
            out_class_reg  <= res_class_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign rule_ident_out = out_ident_reg;
    assign class_out      = out_class_reg;

endmodule

`default_nettype wire

// ===== hdl/ordered_rule_classifier.sv =====
// Ordered first-match rule classifier, top level: sequencer, datapath, channels.
// Depends on orc_pkg, orc_if, orc_ctrl, orc_datapath and the assertion macros header.
//
// Each policy slot keeps an ordered table of up to RULES_PER_POLICY rules
// (source address, destination address, class, identifier) in one shared rule
// RAM with a registered read port. Add appends a rule and returns a fresh
// identifier from a global counter that starts at 1 and skips zero on wrap;
// remove finds a rule by identifier and closes the gap; classify returns the
// class of the first rule whose two addresses both match, else the best-effort
// class from the configuration register. One word is in work at a time.
// Add and every failing case that needs no table walk go from decode straight to
// the result and its delivery; classify and remove first walk the slot's table of
// fill rules, reading one RAM entry per cycle, and the remove shift moves one entry
// per cycle over the same port pair; fill is at most RULES_PER_POLICY. The result
// sits in an output register, so a new word may be taken while the previous
// result waits.
// No clearing pass runs after reset: only entries below a slot's fill are read.
// Write best_effort_class only while the block is idle.
`default_nettype none

`include "ordered_rule_classifier_defines.svh"

module ordered_rule_classifier #(
    parameter int POLICY_SLOTS     = 4,
    parameter int RULES_PER_POLICY = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    orc_req_if.sink                          req,
    orc_resp_if.source                       resp,
    input  wire logic                        cfg_we,
    input  wire logic [orc_pkg::CLASS_W-1:0] cfg_data
);
    import orc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;
    logic       in_ready;

    // sequencer: hold the item while it walks, drop ready until the result reaches the output register
    orc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    assign req.ready = in_ready;

    // datapath: table RAM, fill counts, identifier counter, output register
    orc_datapath #(
        .POLICY_SLOTS     (POLICY_SLOTS),
        .RULES_PER_POLICY (RULES_PER_POLICY)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .st                  (st),
        .operation           (req.operation),
        .policy_slot         (req.policy_slot),
        .source_address      (req.source_address),
        .destination_address (req.destination_address),
        .class_in            (req.class_in),
        .rule_ident_in       (req.rule_ident_in),
        .cfg_we              (cfg_we),
        .cfg_data            (cfg_data),
        .out_valid           (resp.valid),
        .out_ready           (resp.ready),
        .status              (resp.status),
        .rule_ident_out      (resp.rule_ident_out),
        .class_out           (resp.class_out)
    );

    // a finished result never overwrites one still waiting
    `ORC_ASSERT_NOW(a_out_load_free, cmd.out_load, !resp.valid || resp.ready, "result overwritten")
    // the walk never steps past the slot's fill
    `ORC_ASSERT_NOW(a_scan_in_fill, cmd.scan_adv, !st.last, "walk beyond fill")
    // an append only lands in a valid slot with room
    `ORC_ASSERT_NOW(a_add_room, cmd.wr_add, st.slot_ok && !st.full, "append into full table")
    // a taken word blocks the next one in the following cycle
    `ORC_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready while busy")

endmodule

`default_nettype wire

// ===== tb/rule_table_checker.sv =====
`timescale 1ns / 100ps
// Reply checker for the ordered rule classifier: watches the request and reply
// channels and the best-effort register port, predicts every reply and compares.
// Depends on orc_pkg and the orc_req_if / orc_resp_if interfaces.

module rule_table_checker #(
    parameter int POLICY_SLOTS     = 4,
    parameter int RULES_PER_POLICY = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    orc_req_if                          req,
    orc_resp_if                         resp,
    input  logic                        cfg_we,
    input  logic [orc_pkg::CLASS_W-1:0] cfg_data,
    output int                          fault_count,
    output int                          replies_awaited
);
    import orc_pkg::*;

    localparam int   MAX_REPORTS = 10;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic               status;
        logic [IDENT_W-1:0] ident;
        logic [CLASS_W-1:0] cls;
    } reply_t;

    logic [ADRS_W-1:0]  rule_src_tbl   [POLICY_SLOTS][RULES_PER_POLICY];
    logic [ADRS_W-1:0]  rule_dst_tbl   [POLICY_SLOTS][RULES_PER_POLICY];
    logic [CLASS_W-1:0] rule_class_tbl [POLICY_SLOTS][RULES_PER_POLICY];
    logic [IDENT_W-1:0] rule_ident_tbl [POLICY_SLOTS][RULES_PER_POLICY];
    int                 slot_fill      [POLICY_SLOTS];
    logic [IDENT_W-1:0] ident_counter;
    logic [CLASS_W-1:0] fallback_class;
    reply_t             awaited_replies[$];

    // Apply one request word to the shadow tables and return its reply.
    function automatic reply_t predict_reply(
        input logic [OP_W-1:0]    op,
        input logic [SLOT_W-1:0]  slot,
        input logic [ADRS_W-1:0]  src,
        input logic [ADRS_W-1:0]  dst,
        input logic [CLASS_W-1:0] cls,
        input logic [IDENT_W-1:0] rid
    );
        reply_t r;
        int     fill;
        int     hit;
        r   = '{status: STATUS_FAIL, ident: '0, cls: '0};
        hit = -1;
        if (int'(slot) >= POLICY_SLOTS)
            return r;
        fill = slot_fill[slot];
        case (op)
            OP_ADD:
                if (fill < RULES_PER_POLICY)
                begin
                    rule_src_tbl[slot][fill]   = src;
                    rule_dst_tbl[slot][fill]   = dst;
                    rule_class_tbl[slot][fill] = cls;
                    rule_ident_tbl[slot][fill] = ident_counter;
                    slot_fill[slot]            = fill + 1;
                    r.status      = STATUS_OK;
                    r.ident       = ident_counter;
                    ident_counter = ident_counter + 1'b1;
                    // zero is never handed out
                    if (ident_counter == '0)
                        ident_counter = IDENT_W'(1);
                end
            OP_REMOVE:
                if (rid != '0)
                begin
                    for (int j = 0; j < fill; j++)
                        if (hit < 0 && rule_ident_tbl[slot][j] == rid)
                            hit = j;
                    if (hit >= 0)
                    begin
                        for (int k = hit; k + 1 < fill; k++)
                        begin
                            rule_src_tbl[slot][k]   = rule_src_tbl[slot][k+1];
                            rule_dst_tbl[slot][k]   = rule_dst_tbl[slot][k+1];
                            rule_class_tbl[slot][k] = rule_class_tbl[slot][k+1];
                            rule_ident_tbl[slot][k] = rule_ident_tbl[slot][k+1];
                        end
                        slot_fill[slot] = fill - 1;
                        r.status        = STATUS_OK;
                    end
                end
            OP_CLASSIFY:
            begin
                for (int j = 0; j < fill; j++)
                    if (hit < 0 && rule_src_tbl[slot][j] == src
                        && rule_dst_tbl[slot][j] == dst)
                        hit = j;
                r.status = STATUS_OK;
                if (hit >= 0)
                    r.cls = rule_class_tbl[slot][hit];
                else
                    r.cls = fallback_class;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic flag_fault(input string what, input logic [IDENT_W-1:0] want,
                              input logic [IDENT_W-1:0] got);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            foreach (slot_fill[s])
                slot_fill[s] = 0;
            ident_counter  = IDENT_W'(1);
            fallback_class = '0;
            awaited_replies.delete();
        end
        else
        begin
            if (cfg_we)
                fallback_class = cfg_data;
            if (req.valid && req.ready)
                awaited_replies.push_back(predict_reply(req.operation, req.policy_slot,
                    req.source_address, req.destination_address, req.class_in,
                    req.rule_ident_in));
            if (resp.valid && resp.ready)
            begin
                if (awaited_replies.size() == 0)
                    flag_fault("reply with nothing awaited (ident)", '0, resp.rule_ident_out);
                else
                begin
                    want = awaited_replies.pop_front();
                    if (resp.status !== want.status)
                        flag_fault("status", IDENT_W'(want.status), IDENT_W'(resp.status));
                    if (resp.rule_ident_out !== want.ident)
                        flag_fault("rule_ident_out", want.ident, resp.rule_ident_out);
                    if (resp.class_out !== want.cls)
                        flag_fault("class_out", IDENT_W'(want.cls), IDENT_W'(resp.class_out));
                end
            end
        end
        replies_awaited = awaited_replies.size();
    end

endmodule

// ===== tb/ordered_rule_classifier_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the ordered rule classifier: clock, reset, request and
// reply traffic, best-effort register writes and the final verdict.
// Depends on orc_pkg, the channel interfaces, rule_table_checker and the block.

module ordered_rule_classifier_tb;
    import orc_pkg::*;

    localparam int POLICY_SLOTS     = 4;
    localparam int RULES_PER_POLICY = 16;
    localparam int RANDOM_WORDS     = 1922;
    localparam int PHASES           = 6;
    // Longest walk is a full table plus decode, result and deliver, with margin.
    localparam int SETTLE_CYCLES    = RULES_PER_POLICY + 8;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam logic [OP_W-1:0]   OP_UNKNOWN = 2'd3;
    localparam logic [ADRS_W-1:0] HOT_ADDR   = 32'hC0A8_0001;
    localparam logic [ADRS_W-1:0] HOT_PEER   = 32'hC0A8_00FE;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CLASS_W-1:0] cfg_data;
    int                 fault_count;
    int                 replies_awaited;
    int                 words_sent;
    int                 replies_taken;
    bit                 sender_idles;
    bit                 receiver_idles;

    // Identifiers believed live in each slot, only used to aim removes at
    // rules that exist; the checker owns the real prediction.
    logic [IDENT_W-1:0] ident_shadow;
    logic [IDENT_W-1:0] live_idents [POLICY_SLOTS][$];

    orc_req_if  req ();
    orc_resp_if resp ();

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    ordered_rule_classifier #(
        .POLICY_SLOTS     (POLICY_SLOTS),
        .RULES_PER_POLICY (RULES_PER_POLICY)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .resp     (resp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    rule_table_checker #(
        .POLICY_SLOTS     (POLICY_SLOTS),
        .RULES_PER_POLICY (RULES_PER_POLICY)
    ) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .resp            (resp),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .fault_count     (fault_count),
        .replies_awaited (replies_awaited)
    );

    // Mostly a few hot addresses so that classify hits often and the same
    // address pair can sit in several rules; the rest is fully random.
    function automatic logic [ADRS_W-1:0] pick_address();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 6)
            return 32'h0000_0000;
        else if (sel < 12)
            return 32'hFFFF_FFFF;
        else if (sel < 17)
            return HOT_ADDR;
        return $urandom();
    endfunction

    // Offer one request word, after an optional gap, and hold it until taken.
    // Valid is lowered only when a gap follows, so back-to-back words never
    // see valid dropped and raised within one time step.
    task automatic offer_word(
        input logic [OP_W-1:0]    op,
        input logic [SLOT_W-1:0]  slot,
        input logic [ADRS_W-1:0]  src,
        input logic [ADRS_W-1:0]  dst,
        input logic [CLASS_W-1:0] cls,
        input logic [IDENT_W-1:0] rid
    );
        int gap;
        gap = sender_idles ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid               <= 1'b1;
        req.operation           <= op;
        req.policy_slot         <= slot;
        req.source_address      <= src;
        req.destination_address <= dst;
        req.class_in            <= cls;
        req.rule_ident_in       <= rid;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        words_sent++;
        // Track live identifiers so later removes can be aimed at them.
        if (op == OP_ADD && live_idents[slot].size() < RULES_PER_POLICY)
        begin
            live_idents[slot].push_back(ident_shadow);
            ident_shadow = (ident_shadow == '1) ? 1 : ident_shadow + 1'b1;
        end
        else if (op == OP_REMOVE && rid != '0)
        begin
            for (int j = 0; j < live_idents[slot].size(); j++)
                if (live_idents[slot][j] == rid)
                begin
                    live_idents[slot].delete(j);
                    break;
                end
        end
    endtask

    // Drop valid and hold off until every awaited reply is in, then let the
    // block run out its longest walk before anything else happens.
    task automatic settle_block();
        req.valid <= 1'b0;
        do
            @(negedge clk);
        while (replies_awaited != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reply side: a random stall per word, plus a long hold-off now and then
    // so that the output register and the word in work back up into the input.
    initial
    begin : reply_drain
        int stall;
        resp.ready    = 1'b0;
        replies_taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = receiver_idles ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                resp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            resp.ready <= 1'b1;
            @(posedge clk);
            while (!resp.valid)
                @(posedge clk);
            replies_taken++;
            if (replies_taken % 700 == 350)
            begin
                resp.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int                 i;
        int                 phase;
        int                 pick;
        int                 slot_pick;
        int                 fill_now;
        logic [OP_W-1:0]    op_pick;
        logic [IDENT_W-1:0] rid_pick;
        logic [IDENT_W-1:0] first_ident;

        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_data                = '0;
        req.valid               = 1'b0;
        req.operation           = OP_ADD;
        req.policy_slot         = '0;
        req.source_address      = '0;
        req.destination_address = '0;
        req.class_in            = '0;
        req.rule_ident_in       = '0;
        ident_shadow            = 1;
        words_sent              = 0;
        sender_idles            = 1'b1;
        receiver_idles          = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty tables and malformed words, best-effort class still at reset.
        offer_word(OP_CLASSIFY, 2'd0, 32'h0, 32'h0, 3'd0, '0);
        offer_word(OP_REMOVE, 2'd0, 32'h0, 32'h0, 3'd0, '0);              // identifier zero
        offer_word(OP_REMOVE, 2'd0, '1, '1, 3'd7, '1);                      // not found
        offer_word(OP_UNKNOWN, 2'd2, '1, '1, 3'd7, '1);

        // Fill slot one to the brim. Rules three and nine share an address
        // pair with different classes, so first-match order is visible.
        first_ident = ident_shadow;
        for (i = 0; i < RULES_PER_POLICY; i++)
            offer_word(OP_ADD, 2'd1,
                       (i == 0) ? 32'h0 : (i == 3 || i == 9) ? HOT_ADDR : 32'h0A00_0000 + i,
                       (i == 0) ? 32'hFFFF_FFFF : (i == 3 || i == 9) ? HOT_PEER
                                                                    : 32'h0B00_0000 + i,
                       (i == 9) ? 3'd6 : 3'(i), $urandom());
        offer_word(OP_ADD, 2'd1, '1, '1, 3'd7, '0);                         // table full
        offer_word(OP_CLASSIFY, 2'd1, HOT_ADDR, HOT_PEER, 3'd0, '0);
        offer_word(OP_REMOVE, 2'd1, 32'h0, 32'h0, 3'd0, first_ident + 3);
        offer_word(OP_CLASSIFY, 2'd1, HOT_ADDR, HOT_PEER, 3'd0, '0);
        // Remove head and tail, then look up a rule that moved down and the removed head.
        offer_word(OP_REMOVE, 2'd1, 32'h0, 32'h0, 3'd0, first_ident);
        offer_word(OP_REMOVE, 2'd1, 32'h0, 32'h0, 3'd0, first_ident + RULES_PER_POLICY - 1);
        offer_word(OP_CLASSIFY, 2'd1, 32'h0A00_0007, 32'h0B00_0007, 3'd0, '0);
        offer_word(OP_CLASSIFY, 2'd1, 32'h0, 32'hFFFF_FFFF, 3'd0, '0);

        // Random phases, each under a best-effort class and idling mix set at its start;
        // the first two take the extremes of the register.
        for (phase = 0; phase < PHASES; phase++)
        begin
            settle_block();
            cfg_we   <= 1'b1;
            cfg_data <= (phase == 0) ? 3'd7 : (phase == 1) ? 3'd0 : 3'($urandom_range(0, 7));
            @(posedge clk);
            cfg_we   <= 1'b0;
            sender_idles   = (phase != 1 && phase != 3);
            receiver_idles = (phase != 1 && phase != 2);
            repeat (RANDOM_WORDS / PHASES)
            begin
                slot_pick = $urandom_range(0, POLICY_SLOTS - 1);
                fill_now  = live_idents[slot_pick].size();
                pick      = $urandom_range(0, 99);
                rid_pick  = $urandom();
                // Lean towards removes as a table nears full, so that both
                // the full case and long walks keep turning up.
                if (pick < 4)
                    op_pick = OP_UNKNOWN;
                else if (pick < ((fill_now > 11) ? 30 : 46))
                    op_pick = OP_ADD;
                else if (pick < 70)
                begin
                    op_pick = OP_REMOVE;
                    pick    = $urandom_range(0, 9);
                    if (fill_now > 0 && pick < 7)
                        rid_pick = live_idents[slot_pick][$urandom_range(0, fill_now - 1)];
                    else if (pick == 7)
                        rid_pick = '0;
                end
                else
                    op_pick = OP_CLASSIFY;
                offer_word(op_pick, SLOT_W'(slot_pick), pick_address(), pick_address(),
                           3'($urandom_range(0, 7)), rid_pick);
            end
        end
        settle_block();

        $display("Covered %0d request words and %0d replies under %0d best-effort settings,",
                 words_sent, replies_taken, PHASES + 1);
        $display("including full tables, ordered removal and %0d-cycle reply hold-offs.",
                 LONG_HOLD_CYCLES);
        if (fault_count == 0)
            $display("PASS ordered_rule_classifier");
        else
            $display("FAIL ordered_rule_classifier");
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial
    begin : watchdog
        #8_000_000;
        $display("FAIL ordered_rule_classifier");
        $finish;
    end

endmodule
